// ===== sv/prl_pkg.sv =====
// Shared constants and controller/datapath handshake types for the rate limiter.
package prl_pkg;

    localparam int          SLOTS_DEF  = 8;
    localparam int          DATA_W     = 32;
    localparam int          SLOT_OUT_W = 3;
    localparam logic [31:0] TTL_RESET  = 32'd60000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/prl_req_if.sv =====
// Request channel: client address, current time and minimum interval.
interface prl_req_if;
    logic                        valid;
    logic                        ready;
    logic [prl_pkg::DATA_W-1:0] client_addr;
    logic [prl_pkg::DATA_W-1:0] now_ms;
    logic [prl_pkg::DATA_W-1:0] min_interval_ms;

    modport source (output valid, output client_addr, output now_ms,
                    output min_interval_ms, input ready);
    modport sink   (input valid, input client_addr, input now_ms,
                    input min_interval_ms, output ready);
endinterface

// ===== sv/prl_rsp_if.sv =====
// Response channel: limit decision and slot index.
interface prl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            limited;
    logic [prl_pkg::SLOT_OUT_W-1:0] slot_used;

    modport source (output valid, output limited, output slot_used, input ready);
    modport sink   (input valid, input limited, input slot_used, output ready);
endinterface

// ===== sv/prl_cfg_if.sv =====
// Configuration write channel carrying the idle timeout.
interface prl_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [prl_pkg::DATA_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/prl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = prl_pkg::SLOTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/prl_ctrl.sv =====
// Controller state machine: accept, scan the slot table, then commit the result.
module prl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  prl_pkg::t_sts i_sts,
    output prl_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Wait for the output register to drain before committing.
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/prl_dp.sv =====
// Datapath: slot table, scan tracking, interval test and output register.
module prl_dp #(
    parameter int SLOTS = prl_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  prl_pkg::t_cmd                  i_cmd,
    output prl_pkg::t_sts                  o_sts,
    input  logic [prl_pkg::DATA_W-1:0]     i_client_addr,
    input  logic [prl_pkg::DATA_W-1:0]     i_now_ms,
    input  logic [prl_pkg::DATA_W-1:0]     i_min_interval_ms,
    input  logic                           i_cfg_we,
    input  logic [prl_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                           i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic                           o_limited,
    output logic [prl_pkg::SLOT_OUT_W-1:0] o_slot_used
);

    localparam int DW  = prl_pkg::DATA_W;
    localparam int SW  = prl_pkg::SLOT_OUT_W;
    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = IW + 1;
    localparam logic [CW-1:0] CNT_END  = CW'(SLOTS);
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    // Request and configuration registers.
    logic [DW-1:0] r_ttl;
    logic [DW-1:0] r_addr;
    logic [DW-1:0] r_now;
    logic [DW-1:0] r_ivl;

    // Scan pipeline: read issue counter and the slot being checked.
    logic [CW-1:0] r_rd_cnt;
    logic          r_ck_vld;
    logic [IW-1:0] r_ck_idx;
    logic          r_ck_slot_v;

    // Scan results.
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [DW-1:0] r_tgt_time;
    logic [IW-1:0] r_old_idx;
    logic [DW-1:0] r_old_time;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;

    logic [SLOTS-1:0] r_slot_vld;

    logic          r_out_vld;
    logic          r_out_lim;
    logic [SW-1:0] r_out_slot;

    logic            rd_en;
    logic [IW-1:0]   rd_idx;
    logic [2*DW-1:0] rd_data;
    logic [DW-1:0]   ck_addr;
    logic [DW-1:0]   ck_time;
    logic [DW-1:0]   ck_age;
    logic            ck_expired;
    logic [DW-1:0]   pa;
    logic [DW-1:0]   pt;
    logic            ck_match;
    logic            ck_act;

    logic [IW-1:0]   fin_idx;
    logic [DW-1:0]   fin_time;
    logic [DW-1:0]   fin_age;
    logic            fin_lim;
    logic [DW-1:0]   fin_new_time;
    logic [IW+SW-1:0] fin_idx_ext;

    assign rd_en  = i_cmd.scan && (r_rd_cnt < CNT_END);
    assign rd_idx = r_rd_cnt[IW-1:0];

    prl_ram #(
        .WIDTH (2 * DW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (fin_idx),
        .i_wdata ({r_addr, fin_new_time}),
        .i_re    (rd_en),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    // A slot that was never written, or was freed, reads as free with time zero.
    assign ck_addr    = r_ck_slot_v ? rd_data[2*DW-1:DW] : '0;
    assign ck_time    = r_ck_slot_v ? rd_data[DW-1:0]    : '0;
    assign ck_age     = r_now - ck_time;
    assign ck_expired = (ck_addr != '0) && (ck_age > r_ttl);
    assign pa         = ck_expired ? '0 : ck_addr;
    assign pt         = ck_expired ? '0 : ck_time;
    assign ck_match   = (pa == r_addr);
    assign ck_act     = i_cmd.scan && r_ck_vld;

    assign o_sts.done     = ck_act && (ck_match || (r_ck_idx == IDX_LAST));
    assign o_sts.out_free = !r_out_vld || i_rsp_ready;

    // Final decision: the matched slot, else the first free, else the oldest.
    always_comb begin
        if (r_hit) begin
            fin_idx  = r_hit_idx;
            fin_time = r_tgt_time;
        end else if (r_free_found) begin
            fin_idx  = r_free_idx;
            fin_time = '0;
        end else begin
            fin_idx  = r_old_idx;
            fin_time = '0;
        end
    end

    assign fin_age      = r_now - fin_time;
    assign fin_lim      = fin_age < r_ivl;
    assign fin_new_time = fin_lim ? fin_time : r_now;
    assign fin_idx_ext  = {{SW{1'b0}}, fin_idx};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl        <= prl_pkg::TTL_RESET;
            r_rd_cnt     <= '0;
            r_ck_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_slot_vld   <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ttl <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_rd_cnt     <= '0;
                r_ck_vld     <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_ck_vld <= rd_en;
                if (rd_en) begin
                    r_rd_cnt <= r_rd_cnt + CW'(1);
                end
            end
            if (ck_act) begin
                if (ck_expired) begin
                    r_slot_vld[r_ck_idx] <= 1'b0;
                end
                if (ck_match) begin
                    r_hit <= 1'b1;
                end else if ((pa == '0) && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_slot_vld[fin_idx] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= i_client_addr;
            r_now  <= i_now_ms;
            r_ivl  <= i_min_interval_ms;
        end
        if (rd_en) begin
            r_ck_idx    <= rd_idx;
            r_ck_slot_v <= r_slot_vld[rd_idx];
        end
        if (ck_act) begin
            if (ck_match) begin
                r_hit_idx  <= r_ck_idx;
                r_tgt_time <= pt;
            end else begin
                if ((r_ck_idx == '0) || (pt < r_old_time)) begin
                    r_old_idx  <= r_ck_idx;
                    r_old_time <= pt;
                end
                if ((pa == '0) && !r_free_found) begin
                    r_free_idx <= r_ck_idx;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out_lim  <= fin_lim;
            r_out_slot <= fin_idx_ext[SW-1:0];
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_limited   = r_out_lim;
    assign o_slot_used = r_out_slot;

endmodule

// ===== sv/per_client_rate_limiter.sv =====
// Top level of the per-client minimum-interval rate limiter.
//
// Each request beat carries a client address, the current millisecond time and a minimum
// interval, and produces exactly one response beat saying whether the request is limited
// and which table slot served it. The table holds SLOTS entries of address and last
// accepted time in a small RAM that is read one slot per cycle during the scan. A request
// is accepted, then its slots are read from the RAM, whose read data is registered, and
// checked in order up to the first match (at most SLOTS slots), and then the result is
// committed. The commit waits while the previous response beat is still held in the
// output register, so a stalled receiver delays it. During the scan, occupied slots idle
// longer than the timeout are freed, and on a miss the client takes the first free slot
// or else the slot with the oldest stored time. The result sits in an output register,
// so a new request is taken as soon as the previous one has been committed, even while
// its response still waits. Slot valid bits are cleared by reset, so the table starts
// empty with no clearing pass. The timeout register is written through the
// configuration channel, which is always ready; it should only be written while no
// request is in flight.
module per_client_rate_limiter #(
    parameter int SLOTS = prl_pkg::SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prl_req_if.sink   i_req,
    prl_rsp_if.source o_rsp,
    prl_cfg_if.sink   i_cfg
);

    prl_pkg::t_cmd cmd;
    prl_pkg::t_sts sts;

    // The timeout register takes a write on any cycle.
    assign i_cfg.ready = 1'b1;

    prl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    prl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_client_addr     (i_req.client_addr),
        .i_now_ms          (i_req.now_ms),
        .i_min_interval_ms (i_req.min_interval_ms),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_data        (i_cfg.data),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_limited         (o_rsp.limited),
        .o_slot_used       (o_rsp.slot_used)
    );

endmodule

// ===== sv/prl_chk.sv =====
// Port-level checker for the rate limiter, bound to the top level.
module prl_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic                            i_rsp_limited,
    input logic [prl_pkg::SLOT_OUT_W-1:0] i_rsp_slot_used
);

    // Requests accepted whose response beat has not yet been taken.
    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    always_comb begin
        n_pend = r_pend;
        if (req_acc && !rsp_acc) begin
            n_pend = r_pend + 2'd1;
        end else if (rsp_acc && !req_acc) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_limited)
            && $stable(i_rsp_slot_used))
        else $error("response beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req_ready)
        else $error("request taken while the previous one was still scanning");

    a_rsp_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("response appeared without a request in progress");

    a_no_invented_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pend != 2'd0)
        else $error("response beat without an outstanding request");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two requests outstanding");

endmodule

bind per_client_rate_limiter prl_chk u_prl_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_limited   (o_rsp.limited),
    .i_rsp_slot_used (o_rsp.slot_used)
);
